### sv/tctt_pkg.sv
// Shared widths, pipeline layout and conversion constants for the thermal
// code to temperature converter. No dependencies; every other file imports it.
package tctt_pkg;

   // Field widths.
   localparam int CODE_W = 16;
   localparam int TEMP_W = 32;
   localparam int CAL_W  = 32;

   // Intermediate widths.
   localparam int FACTOR_W = 18;   // code * 3318 / 1024 stays below 2^18
   localparam int READ_W   = 19;   // code * 4342 / 1024 stays below 2^19
   localparam int DEN_W    = 19;   // 65536 + factor stays below 2^19
   localparam int NUM_W    = READ_W + 16;
   localparam int QUOT_W   = 17;   // normalized reading stays below 2^17
   localparam int SUM_W    = 18;   // reading plus signed trim
   localparam int PROD_W   = 32;   // sum times slope
   localparam int SCALE_W  = 48;   // offset product times 100000

   // Conversion constants.
   localparam int K_SLOPE_A   = 9411;
   localparam int K_OFFSET_B  = 3159;
   localparam int K_M_1024    = 4342;
   localparam int K_N_1024    = 3318;
   localparam int K_SCALE     = 100000;
   localparam int K_ZERO_C_UK = 273150000;
   localparam int K_ONE       = 65536;
   localparam int K_OFFSET_BIAS = K_OFFSET_B * K_ONE;

   // Pipeline layout: one entry stage, one stage per quotient bit, then the
   // slope multiply, the scale multiply and the output register.
   localparam int DIV_STEPS = QUOT_W;
   localparam int S_ENTRY   = 0;
   localparam int S_MUL     = DIV_STEPS + 1;
   localparam int S_SCALE   = DIV_STEPS + 2;
   localparam int S_OUT     = DIV_STEPS + 3;
   localparam int NUM_STAGES = DIV_STEPS + 4;

endpackage

### sv/tctt_req_if.sv
// Input channel of the converter: valid, ready and one raw sensor code.
// Depends on tctt_pkg for the field width.
interface tctt_req_if import tctt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] raw_code;

   modport source (output valid, output raw_code, input ready);
   modport sink   (input valid, input raw_code, output ready);
endinterface

### sv/tctt_rsp_if.sv
// Result channel of the converter: valid, ready and one signed temperature.
// Depends on tctt_pkg for the field width.
interface tctt_rsp_if import tctt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_microkelvin;

   modport source (output valid, output temperature_microkelvin, input ready);
   modport sink   (input valid, input temperature_microkelvin, output ready);
endinterface

### sv/tctt_csr_if.sv
// Configuration write channel of the converter: valid, ready and the
// calibration word. Depends on tctt_pkg for the register width.
interface tctt_csr_if import tctt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAL_W-1:0] calibration_word;

   modport source (output valid, output calibration_word, input ready);
   modport sink   (input valid, input calibration_word, output ready);
endinterface

### sv/thermal_code_to_temperature.sv
// Top level of the thermal code to temperature converter: a 21-stage pipeline.
// Depends on tctt_pkg and the tctt_req_if, tctt_rsp_if and tctt_csr_if channels.
//
// The converter turns each raw 16-bit sensor code into a temperature in
// microkelvin, using the trim offset held in the calibration word. It
// accepts one code per clock and delivers one result per clock once the
// pipeline is full and while the result side does not stall. The depth
// is set mostly by the division by (65536 + factor), which is done by a
// restoring divider with one quotient bit per stage (17 stages). The
// divider sits behind the entry stage and is followed by a slope
// multiply, a scale multiply and the output register. Every stage carries
// its own valid bit and loads whenever it is empty or its successor moves,
// so a stall on the result side fills bubbles before it holds the input,
// and nothing is lost or repeated. The calibration word is taken on any
// configuration transfer and should only change while no code is in
// flight; there is no clearing pass after reset.
module thermal_code_to_temperature import tctt_pkg::*; (
   input logic        clock,
   input logic        reset,
   tctt_req_if.sink   req_ch,
   tctt_rsp_if.source rsp_ch,
   tctt_csr_if.sink   csr_ch
);

   // Configuration register.
   logic [CAL_W-1:0] cal_ff;

   // Per-stage valid bits and the backward ready chain.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   ready_w;

   // Divider stages: entry stage and one stage per quotient bit.
   logic [NUM_W-1:0]  rem_ff  [0:DIV_STEPS];
   logic [DEN_W-1:0]  den_ff  [0:DIV_STEPS];
   logic [QUOT_W-1:0] quot_ff [0:DIV_STEPS];

   // Tail stages.
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [SCALE_W-1:0] scaled_ff;
   logic signed [TEMP_W-1:0]  temp_ff;

   // The configuration port never pushes back.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_ch.valid) begin
         cal_ff <= csr_ch.calibration_word;
      end
   end

   // A stage may load when it is empty or when its own contents move on.
   assign ready_w[NUM_STAGES] = rsp_ch.ready;
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
      assign ready_w[k] = !valid_ff[k] || ready_w[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready_w[S_ENTRY]) begin
            valid_ff[S_ENTRY] <= req_ch.valid;
         end
         for (int k = S_ENTRY + 1; k < NUM_STAGES; k++) begin
            if (ready_w[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_ch.ready = ready_w[S_ENTRY];

   // Entry stage: both constant scalings of the code, then the numerator
   // (reading times 65536) and the divisor (65536 plus factor).
   logic [CODE_W+12-1:0] factor_prod_w;
   logic [CODE_W+13-1:0] read_prod_w;
   logic [FACTOR_W-1:0]  factor_w;
   logic [READ_W-1:0]    reading_w;
   logic [NUM_W-1:0]     num_in;
   logic [DEN_W-1:0]     den_in;

   always_comb begin
      factor_prod_w = req_ch.raw_code * (CODE_W+12)'(K_N_1024);
      read_prod_w   = req_ch.raw_code * (CODE_W+13)'(K_M_1024);
      factor_w      = factor_prod_w[10 +: FACTOR_W];
      reading_w     = read_prod_w[10 +: READ_W];
      num_in        = {reading_w, 16'd0};
      den_in        = DEN_W'(K_ONE) + DEN_W'(factor_w);
   end

   always_ff @(posedge clock) begin
      if (ready_w[S_ENTRY] && req_ch.valid) begin
         rem_ff[0]  <= num_in;
         den_ff[0]  <= den_in;
         quot_ff[0] <= '0;
      end
   end

   // Restoring division, most significant quotient bit first. The quotient
   // is known to stay below 2^17, so the remainder always stays below the
   // divisor shifted one place above the bit under test.
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      localparam int SH = DIV_STEPS - k;
      logic [NUM_W-1:0]  trial_w;
      logic [NUM_W-1:0]  rem_in;
      logic [QUOT_W-1:0] quot_in;

      always_comb begin
         trial_w = NUM_W'(den_ff[k-1]) << SH;
         rem_in  = rem_ff[k-1];
         quot_in = quot_ff[k-1];
         if (rem_ff[k-1] >= trial_w) begin
            rem_in      = rem_ff[k-1] - trial_w;
            quot_in[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (ready_w[k] && valid_ff[k-1]) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_ff[k-1];
            quot_ff[k] <= quot_in;
         end
      end
   end

   // Trim offset: zero for a version-zero word, else sign and magnitude.
   logic signed [SUM_W-1:0] trim_w;
   logic signed [SUM_W-1:0] sum_w;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      if (cal_ff[31:24] == 8'd0) begin
         trim_w = '0;
      end else if (cal_ff[15]) begin
         trim_w = -$signed(SUM_W'(cal_ff[14:0]));
      end else begin
         trim_w = $signed(SUM_W'(cal_ff[14:0]));
      end
      sum_w   = $signed(SUM_W'(quot_ff[DIV_STEPS])) + trim_w;
      prod_in = PROD_W'(sum_w * $signed(16'(K_SLOPE_A)));
   end

   always_ff @(posedge clock) begin
      if (ready_w[S_MUL] && valid_ff[S_MUL-1]) begin
         prod_ff <= prod_in;
      end
   end

   // Remove the sensor's zero point and scale by 100000.
   logic signed [PROD_W-1:0]  biased_w;
   logic signed [SCALE_W-1:0] scaled_in;

   always_comb begin
      biased_w  = prod_ff - $signed(PROD_W'(K_OFFSET_BIAS));
      scaled_in = SCALE_W'(biased_w * $signed(18'(K_SCALE)));
   end

   always_ff @(posedge clock) begin
      if (ready_w[S_SCALE] && valid_ff[S_SCALE-1]) begin
         scaled_ff <= scaled_in;
      end
   end

   // Divide by 65536 truncating toward zero: negative values are biased by
   // 65535 before the arithmetic shift. Then move to the Kelvin zero point.
   logic signed [SCALE_W-1:0] rounded_w;
   logic signed [SCALE_W-1:0] shifted_w;
   logic signed [TEMP_W-1:0]  temp_in;

   always_comb begin
      rounded_w = scaled_ff;
      if (scaled_ff[SCALE_W-1]) begin
         rounded_w = scaled_ff + $signed(SCALE_W'(K_ONE - 1));
      end
      shifted_w = rounded_w >>> 16;
      temp_in   = TEMP_W'(shifted_w) + $signed(TEMP_W'(K_ZERO_C_UK));
   end

   always_ff @(posedge clock) begin
      if (ready_w[S_OUT] && valid_ff[S_OUT-1]) begin
         temp_ff <= temp_in;
      end
   end

   assign rsp_ch.valid                   = valid_ff[S_OUT];
   assign rsp_ch.temperature_microkelvin = temp_ff;

   // An empty entry stage always takes the next code.
   a_entry_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[S_ENTRY] |-> req_ch.ready)
      else $error("entry stage empty but input not ready");

   // After the last quotient bit the remainder is below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_STEPS] |-> (rem_ff[DIV_STEPS] < NUM_W'(den_ff[DIV_STEPS])))
      else $error("divider remainder not reduced below divisor");

   // A held entry stage keeps its operands until its successor takes them.
   a_entry_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_ENTRY] && !ready_w[S_ENTRY+1] |=>
         valid_ff[S_ENTRY] && $stable(rem_ff[0]) && $stable(den_ff[0]))
      else $error("stalled entry stage lost its operands");

endmodule

### tb/sv/tb_thermal_code_to_temperature.sv
`timescale 1ns / 100ps
// Self-checking testbench for the thermal code to temperature converter.
// Depends on tctt_pkg and the tctt_req_if, tctt_rsp_if and tctt_csr_if channels.
module tb_thermal_code_to_temperature;
   import tctt_pkg::*;

   // Length of the idle wait in settle(), taken wherever the pipeline has to
   // be empty; it covers the full depth of the pipeline.
   localparam int SETTLE_CYCLES = NUM_STAGES + 4;
   localparam longint FRAC_ONE = 1024;
   localparam int CODES_PER_SETTING = 110;
   localparam int NUM_SETTINGS = 5;
   localparam int NUM_DIRECTED = 22;

   // The offset of a version-zero or negative-zero trim is 0. For code 0,
   // the temperature is then 0 - 3159 * 100000 + 273150000.
   localparam logic signed [TEMP_W-1:0] ZERO_CODE_TEMP = -32'sd42750000;

   // One row of the directed table. When load_cal is set, the calibration
   // word is written first, with the pipeline empty. When pinned is set,
   // the row carries its own expected temperature. Otherwise the predictor
   // works it out.
   typedef struct packed {
      bit                     load_cal;
      bit [CAL_W-1:0]         cal;
      bit [CODE_W-1:0]        code;
      bit                     pinned;
      bit signed [TEMP_W-1:0] pinned_temp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   tctt_req_if req_bus ();
   tctt_rsp_if rsp_bus ();
   tctt_csr_if csr_bus ();

   thermal_code_to_temperature dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Temperatures still owed by the converter, oldest first.
   logic signed [TEMP_W-1:0] pending_temps[$];
   // The calibration word as the converter holds it.
   logic [CAL_W-1:0] cal_shadow = '0;
   int mismatch_count = 0;
   // Idle rates in percent for the sender and the receiver.
   int send_gap_pct = 0;
   int recv_stall_pct = 0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // After reset the trim word is zero.
      '{1'b0, 32'h0000_0000, 16'h0000, 1'b1, ZERO_CODE_TEMP},
      '{1'b0, 32'h0000_0000, 16'hFFFF, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'h0001, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'h8000, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'h7FFF, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'h5555, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'hAAAA, 1'b0, 32'sd0},
      // The most negative trim, with every register bit set.
      '{1'b1, 32'hFFFF_FFFF, 16'h0000, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'hFFFF, 1'b0, 32'sd0},
      // The most positive trim.
      '{1'b1, 32'hFF00_7FFF, 16'h0000, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'hFFFF, 1'b0, 32'sd0},
      // The version field is zero, so the magnitude must be ignored.
      '{1'b1, 32'h00FF_7FFF, 16'h0000, 1'b1, ZERO_CODE_TEMP},
      '{1'b0, 32'h0000_0000, 16'hFFFF, 1'b0, 32'sd0},
      // The sign is set but the magnitude is zero (negative zero).
      '{1'b1, 32'h0100_8000, 16'h0000, 1'b1, ZERO_CODE_TEMP},
      '{1'b0, 32'h0000_0000, 16'h3039, 1'b0, 32'sd0},
      // Bits 23..16 are set with a zero trim and must have no effect.
      '{1'b1, 32'h01FF_0000, 16'h0000, 1'b1, ZERO_CODE_TEMP},
      '{1'b0, 32'h0000_0000, 16'hFFFF, 1'b0, 32'sd0},
      // A small negative trim.
      '{1'b1, 32'h80AA_8001, 16'h03E8, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'h0001, 1'b0, 32'sd0},
      // Back to a zero trim word.
      '{1'b1, 32'h0000_0000, 16'h0000, 1'b1, ZERO_CODE_TEMP},
      '{1'b0, 32'h0000_0000, 16'h7530, 1'b0, 32'sd0},
      '{1'b0, 32'h0000_0000, 16'hFFFE, 1'b0, 32'sd0}
   };

   // The period is 4 ns: 2 ns high and 2 ns low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Works out the temperature for one code under a given trim word, in
   // 64-bit signed arithmetic. Every division truncates toward zero, as
   // SystemVerilog integer division does.
   function automatic logic signed [TEMP_W-1:0] predict_temperature(
      input logic [CODE_W-1:0] code,
      input logic [CAL_W-1:0]  cal
   );
      longint c;
      longint factor;
      longint reading;
      longint trim;
      longint t;
      c = longint'(code);
      factor = (c * K_N_1024) / FRAC_ONE;
      reading = (c * K_M_1024) / FRAC_ONE;
      reading = (reading * K_ONE) / (K_ONE + factor);
      // The trim is a sign-magnitude value. It counts only when the version
      // field is nonzero.
      trim = 0;
      if (cal[31:24] != 8'd0) begin
         trim = longint'(cal[14:0]);
         if (cal[15]) begin
            trim = -trim;
         end
      end
      t = (reading + trim) * K_SLOPE_A;
      t = ((t - longint'(K_OFFSET_B) * K_ONE) * K_SCALE) / K_ONE;
      t = t + K_ZERO_C_UK;
      return t[TEMP_W-1:0];
   endfunction

   // Offers one code and returns at the clock edge of its transfer. The
   // expected temperature is queued at that edge. The call must be made
   // right after a rising edge. When a gap is taken, valid goes low in this
   // time step and rises again in a later one, never in the same one.
   task automatic send_code(
      input logic [CODE_W-1:0]        code,
      input bit                       pinned,
      input logic signed [TEMP_W-1:0] pinned_temp
   );
      if ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_gap_pct);
      end
      req_bus.valid    <= 1'b1;
      req_bus.raw_code <= code;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      pending_temps.push_back(pinned ? pinned_temp : predict_temperature(code, cal_shadow));
   endtask

   // Stops the input, waits until every owed temperature has come back,
   // and then lets the pipeline run empty.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_temps.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the calibration word through the configuration channel. The
   // pipeline must be empty when this is called.
   task automatic write_cal(input logic [CAL_W-1:0] word);
      csr_bus.valid            <= 1'b1;
      csr_bus.calibration_word <= word;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      cal_shadow = word;
      csr_bus.valid <= 1'b0;
   endtask

   // The receiver. It holds ready low during reset and then stalls at
   // the current rate.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // The result checker. Each result transfer is matched against the
   // oldest owed temperature. A transfer with nothing owed is a failure.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_temps.size() == 0) begin
            $error("temperature_microkelvin: none expected, actual %0d",
                   rsp_bus.temperature_microkelvin);
            mismatch_count++;
         end else begin
            if (rsp_bus.temperature_microkelvin !== pending_temps[0]) begin
               $error("temperature_microkelvin: expected %0d, actual %0d",
                      pending_temps[0], rsp_bus.temperature_microkelvin);
               mismatch_count++;
            end
            void'(pending_temps.pop_front());
         end
      end
   end

   // The watchdog. It ends the run if the converter stops delivering.
   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // The main sequence: reset, the directed table, then random codes. The
   // random part has three idling modes. Each mode runs under several trim
   // words, and each word is written with the pipeline empty.
   initial begin
      logic [CAL_W-1:0]  word;
      logic [CODE_W-1:0] code;
      int pick;

      req_bus.valid            <= 1'b0;
      req_bus.raw_code         <= '0;
      csr_bus.valid            <= 1'b0;
      csr_bus.calibration_word <= '0;
      reset                    <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The directed table runs under the first idling mode.
      send_gap_pct   = 18;
      recv_stall_pct = 83;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].load_cal) begin
            settle();
            write_cal(directed_rows[i].cal);
         end
         send_code(directed_rows[i].code, directed_rows[i].pinned,
                   directed_rows[i].pinned_temp);
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_gap_pct   = 18;
               recv_stall_pct = 83;
            end
            1: begin
               send_gap_pct   = 83;
               recv_stall_pct = 18;
            end
            default: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int s = 0; s < NUM_SETTINGS; s++) begin
            // The first mode starts with the extreme trim words. All other settings
            // draw random words, and about a quarter of them get a zero version
            // field.
            word = $urandom();
            if (mode == 0 && s == 0) begin
               word = 32'hFFFF_FFFF;
            end else if (mode == 0 && s == 1) begin
               word = 32'hFF00_7FFF;
            end else if (mode == 0 && s == 2) begin
               word = 32'h0000_0000;
            end else if (mode == 0 && s == 3) begin
               word = 32'h00FF_FFFF;
            end else if ($urandom_range(3) == 0) begin
               word[31:24] = 8'd0;
            end
            settle();
            write_cal(word);
            repeat (CODES_PER_SETTING) begin
               // Most codes span the full range. The rest crowd the top,
               // the bottom and the single-bit values.
               pick = $urandom_range(9);
               code = CODE_W'($urandom());
               if (pick == 7) begin
                  code = 16'hFFFF - 16'($urandom_range(15));
               end else if (pick == 8) begin
                  code = 16'($urandom_range(63));
               end else if (pick == 9) begin
                  code = 16'h0001 << $urandom_range(15);
               end
               send_code(code, 1'b0, '0);
            end
         end
      end

      // Drain all results and let the pipeline run empty. The watchdog
      // bounds the wait.
      settle();
      if (mismatch_count == 0 && pending_temps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
sv/tctt_pkg.sv
sv/tctt_req_if.sv
sv/tctt_rsp_if.sv
sv/tctt_csr_if.sv
sv/thermal_code_to_temperature.sv
tb/sv/tb_thermal_code_to_temperature.sv
